// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the SHA-256 hasher RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset
`define SHA_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sha assertion failed");
// Check that a condition is followed in the next cycle by another
`define SHA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha assertion failed");
`else
`define SHA_ASSERT(name, clk, rst_n, prop)
`define SHA_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/sha_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 hasher.
// No dependencies; imported by the round datapath and the top level.
package sha_pkg;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned NumChain  = 8;
  localparam int unsigned NumSched  = 16;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;
  localparam logic [5:0] LastByte = 6'd63;

  // Round constants
  localparam logic [31:0] SHA_K [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  // Initial chaining value
  localparam logic [31:0] SHA_IV [NumChain] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_RND_A,
    ST_RND_B,
    ST_RND_W,
    ST_RND_T1,
    ST_RND_UPD,
    ST_FIN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_OUT
  } sha_state_e;

  // Strobes from the sequencer to the round datapath
  typedef struct packed {
    logic shift_en;  // shift working vars toward a, new word into h
    logic t1_en;     // register t1 of the current round
    logic upd_en;    // apply the round update
  } sha_rnd_ctrl_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

endpackage

// ===== rtl/sha_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sha_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sha_round.sv =====
// SHA-256 working variables a..h and the round arithmetic.
// Depends on sha_pkg for the strobe struct and the sigma functions.
module sha_round import sha_pkg::*; (
  input  logic          clk_i,
  input  sha_rnd_ctrl_t ctrl_i,
  input  logic [31:0]   shift_word_i,  // word entering at h on a shift
  input  logic [31:0]   k_word_i,      // round constant
  input  logic [31:0]   w_word_i,      // schedule word of the round
  output logic [31:0]   v0_word_o      // variable a, leaves first on a shift
);

  logic [31:0] v_q [NumChain];
  logic [31:0] t1_q;
  logic [31:0] ch;
  logic [31:0] maj;

  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);

  // Shift in or out, or advance one round
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_en) begin
      for (int j = 0; j < NumChain - 1; j++) begin
        v_q[j] <= v_q[j+1];
      end
      v_q[NumChain-1] <= shift_word_i;
    end else if (ctrl_i.upd_en) begin
      v_q[0] <= t1_q + bsig0(v_q[0]) + maj;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1_q;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
    end
    if (ctrl_i.t1_en) begin
      t1_q <= v_q[7] + bsig1(v_q[4]) + ch + k_word_i + w_word_i;
    end
  end

  assign v0_word_o = v_q[0];

endmodule

// ===== rtl/sha256_byte_stream_hasher.sv =====
// SHA-256 byte stream hasher: absorbs one byte per word, emits eight digest words.
// An absorb byte is packed into the schedule RAM; a byte that fills a block starts a
// compression: chain load, 64 rounds (read, schedule word from round 16 on, t1, update), chain update.
// Finish: padding pushes one byte per cycle, one or two compressions follow, then
// each digest word is read from the chain, registered and held until the sink takes it.
// Reset (rst_ni, async, low): control clears at once, chain reads as the initial value.
`include "assert_macros.svh"
module sha256_byte_stream_hasher import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] command (0 absorb, 1 finish)
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index, zero pad
  output logic        m_axis_tlast_o    // last_word
);

  sha_state_e    state_q, state_d;
  sha_rnd_ctrl_t rctl;

  logic [5:0]  fill_q;
  logic [23:0] pack_q;
  logic [60:0] msg_bytes_q;
  logic        fin_mode_q, sent80_q, len_mode_q;
  logic [3:0]  cnt_q;
  logic [5:0]  rnd_q;
  logic [7:0]  chain_valid_q;
  logic [2:0]  chain_ra_q;
  logic [2:0]  emit_idx_q;
  logic        out_valid_q;
  logic [31:0] out_word_q;
  logic [31:0] x16_q, x15_q, w_q;

  logic        s_fire, m_fire, s_ready;
  logic        push_en;
  logic [7:0]  push_data, pad_byte;
  logic [63:0] len_sh;
  logic        sched_we;
  logic [3:0]  sched_wa, sched_ra_a, sched_ra_b;
  logic [31:0] sched_wd, sched_rd_a, sched_rd_b;
  logic        chain_we;
  logic [2:0]  chain_ra, chain_wa;
  logic [31:0] chain_rdata, chain_rd, chain_wd;
  logic [31:0] v0_word;

  assign s_fire = s_axis_tvalid_i && s_ready;
  assign m_fire = out_valid_q && m_axis_tready_i;

  // Padding byte: 0x80, then zeros, then the big-endian bit length at 56..63
  assign len_sh   = {msg_bytes_q, 3'b000} >> {~fill_q[2:0], 3'b000};
  assign pad_byte = !sent80_q ? PadByte :
                    (len_mode_q || fill_q == LenStart) ? len_sh[7:0] : 8'h00;

  // Chain entries not yet written read as the initial value
  assign chain_rd = chain_valid_q[chain_ra_q] ? chain_rdata : SHA_IV[chain_ra_q];
  assign chain_wa = 3'(cnt_q - 4'd1);
  assign chain_wd = chain_rd + v0_word;

  // Schedule write: packed message word on a push, or the round word
  assign sched_we = (push_en && fill_q[1:0] == 2'd3) || state_q == ST_RND_T1;
  assign sched_wa = (state_q == ST_RND_T1) ? rnd_q[3:0] : fill_q[5:2];
  assign sched_wd = (state_q == ST_RND_T1) ? w_q : {pack_q, push_data};

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and strobes
  always_comb begin
    state_d    = state_q;
    s_ready    = 1'b0;
    push_en    = 1'b0;
    push_data  = s_axis_tdata_i;
    rctl       = '0;
    sched_ra_a = rnd_q[3:0];
    sched_ra_b = rnd_q[3:0] + 4'd1;
    chain_ra   = cnt_q[2:0];
    chain_we   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready = 1'b1;
        if (s_fire) begin
          if (s_axis_tuser_i) begin
            state_d = ST_PAD;
          end else begin
            push_en = 1'b1;
            if (fill_q == LastByte) state_d = ST_LOAD;
          end
        end
      end
      ST_PAD: begin
        push_en   = 1'b1;
        push_data = pad_byte;
        if (fill_q == LastByte) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        rctl.shift_en = (cnt_q != 4'd0);
        if (cnt_q == 4'd8) state_d = ST_RND_A;
      end
      ST_RND_A: begin
        state_d = ST_RND_B;
      end
      ST_RND_B: begin
        sched_ra_a = rnd_q[3:0] + 4'd9;
        sched_ra_b = rnd_q[3:0] + 4'd14;
        state_d    = (rnd_q < 6'd16) ? ST_RND_T1 : ST_RND_W;
      end
      ST_RND_W: begin
        state_d = ST_RND_T1;
      end
      ST_RND_T1: begin
        rctl.t1_en = 1'b1;
        state_d    = ST_RND_UPD;
      end
      ST_RND_UPD: begin
        rctl.upd_en = 1'b1;
        state_d     = (rnd_q == 6'd63) ? ST_FIN : ST_RND_A;
      end
      ST_FIN: begin
        chain_we      = (cnt_q != 4'd0);
        rctl.shift_en = (cnt_q != 4'd0);
        if (cnt_q == 4'd8) begin
          state_d = !fin_mode_q ? ST_IDLE : (len_mode_q ? ST_EMIT_RD : ST_PAD);
        end
      end
      ST_EMIT_RD: begin
        chain_ra = emit_idx_q;
        state_d  = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        state_d = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (m_fire) state_d = (emit_idx_q == 3'd7) ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q        <= '0;
      msg_bytes_q   <= '0;
      fin_mode_q    <= 1'b0;
      sent80_q      <= 1'b0;
      len_mode_q    <= 1'b0;
      cnt_q         <= '0;
      rnd_q         <= '0;
      chain_valid_q <= '0;
      emit_idx_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (push_en) fill_q <= fill_q + 6'd1;
      if (state_q == ST_IDLE && s_fire) begin
        if (s_axis_tuser_i) fin_mode_q <= 1'b1;
        else msg_bytes_q <= msg_bytes_q + 61'd1;
      end
      if (state_q == ST_PAD) begin
        sent80_q <= 1'b1;
        if (sent80_q && fill_q == LenStart) len_mode_q <= 1'b1;
      end
      if (state_q == ST_LOAD || state_q == ST_FIN) begin
        cnt_q <= (cnt_q == 4'd8) ? 4'd0 : cnt_q + 4'd1;
      end
      if (state_q == ST_LOAD) rnd_q <= '0;
      else if (state_q == ST_RND_UPD) rnd_q <= rnd_q + 6'd1;
      if (chain_we) chain_valid_q[chain_wa] <= 1'b1;
      if (state_q == ST_EMIT_LD) out_valid_q <= 1'b1;
      // Drop the word once taken; after the last word return to the start state
      if (state_q == ST_EMIT_OUT && m_fire) begin
        out_valid_q <= 1'b0;
        emit_idx_q  <= emit_idx_q + 3'd1;
        if (emit_idx_q == 3'd7) begin
          msg_bytes_q   <= '0;
          fin_mode_q    <= 1'b0;
          sent80_q      <= 1'b0;
          len_mode_q    <= 1'b0;
          chain_valid_q <= '0;
        end
      end
    end
  end

  // Data registers
  always_ff @(posedge clk_i) begin
    chain_ra_q <= chain_ra;
    if (push_en) pack_q <= {pack_q[15:0], push_data};
    if (state_q == ST_RND_B) begin
      x16_q <= sched_rd_a;
      x15_q <= sched_rd_b;
      if (rnd_q < 6'd16) w_q <= sched_rd_a;
    end
    if (state_q == ST_RND_W) begin
      w_q <= x16_q + ssig0(x15_q) + sched_rd_a + ssig1(sched_rd_b);
    end
    if (state_q == ST_EMIT_LD) out_word_q <= chain_rd;
  end

  // Message block and schedule window, one copy per read port
  sha_ram #(.WIDTH(32), .DEPTH(NumSched)) u_sched_a (
    .clk_i   (clk_i),
    .we_i    (sched_we),
    .waddr_i (sched_wa),
    .wdata_i (sched_wd),
    .raddr_i (sched_ra_a),
    .rdata_o (sched_rd_a)
  );

  sha_ram #(.WIDTH(32), .DEPTH(NumSched)) u_sched_b (
    .clk_i   (clk_i),
    .we_i    (sched_we),
    .waddr_i (sched_wa),
    .wdata_i (sched_wd),
    .raddr_i (sched_ra_b),
    .rdata_o (sched_rd_b)
  );

  // Chaining value
  sha_ram #(.WIDTH(32), .DEPTH(NumChain)) u_chain (
    .clk_i   (clk_i),
    .we_i    (chain_we),
    .waddr_i (chain_wa),
    .wdata_i (chain_wd),
    .raddr_i (chain_ra),
    .rdata_o (chain_rdata)
  );

  sha_round u_round (
    .clk_i        (clk_i),
    .ctrl_i       (rctl),
    .shift_word_i (chain_rd),
    .k_word_i     (SHA_K[rnd_q]),
    .w_word_i     (w_q),
    .v0_word_o    (v0_word)
  );

  assign s_axis_tready_o = s_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b00000, emit_idx_q, out_word_q};
  assign m_axis_tlast_o  = (emit_idx_q == 3'd7);

  `SHA_ASSERT(a_ready_no_out, clk_i, rst_ni, s_axis_tready_o |-> !m_axis_tvalid_o)
  `SHA_ASSERT(a_len_after_pad, clk_i, rst_ni, len_mode_q |-> (sent80_q && fin_mode_q))
  `SHA_ASSERT_NEXT(a_full_block, clk_i, rst_ni, push_en && fill_q == LastByte, state_q == ST_LOAD)
  `SHA_ASSERT_NEXT(a_clear_after_digest, clk_i, rst_ni, m_fire && m_axis_tlast_o, chain_valid_q == 8'h00 && fill_q == 6'd0)

endmodule
